/* src/hbfd_pkg.sv */
// Shared types, constants and helpers for the heartbeat failure detector.
package hbfd_pkg;

  // Sizing
  localparam int MAX_NODES  = 32;
  localparam int TIME_WIDTH = 32;
  localparam int IDX_W      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int THR_W      = 32;
  localparam int CMP_W      = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;
  localparam int CNT_W      = 6;
  localparam int NODE_W     = 5;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // Liveness codes
  typedef logic [1:0] live_t;
  localparam live_t LV_ALIVE   = 2'd0;
  localparam live_t LV_SUSPECT = 2'd1;
  localparam live_t LV_DEAD    = 2'd2;
  localparam live_t LV_ABSENT  = 2'd3;

  // Function codes of an input beat
  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK    = 2'd0;
  localparam func_t FUNC_BEAT    = 2'd1;
  localparam func_t FUNC_RECLASS = 2'd2;

  // Configuration register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SUSPECT = 2'd0;
  localparam cfg_idx_t CFG_DEAD    = 2'd1;
  localparam cfg_idx_t CFG_QUORUM  = 2'd2;
  localparam cfg_idx_t CFG_NODES   = 2'd3;

  // One entry of the node state memory
  typedef struct packed {
    logic  heard;
    live_t live;
  } node_ent_t;

  localparam int ENT_W = $bits(node_ent_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP,
    S_WALK
  } hbfd_state_e;

  // Memory index of a small node number
  function automatic logic [IDX_W-1:0] idx_of(input logic [CNT_W-1:0] v);
    logic [IDX_W+CNT_W-1:0] ext;
    ext = (IDX_W+CNT_W)'(v);
    return ext[IDX_W-1:0];
  endfunction

  // Number of nodes in use, clamped to the table size
  function automatic logic [CNT_W-1:0] active_nodes(input logic [CNT_W-1:0] num);
    if (int'(num) > MAX_NODES) return CNT_W'(MAX_NODES);
    return num;
  endfunction

endpackage

/* src/hbfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module hbfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/hbfd_classify.sv */
// Two-stage classifier: registered elapsed time, then threshold compares.
module hbfd_classify import hbfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [TIME_WIDTH-1:0] time_i,
  input  logic [TIME_WIDTH-1:0] stamp_i,
  input  logic                  heard_i,
  input  logic [THR_W-1:0]      suspect_i,
  input  logic [THR_W-1:0]      dead_i,
  output logic                  heard_o,
  output live_t                 live_o
);

  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                  heard_q;
  logic [CMP_W-1:0]      elapsed_x;

  // Elapsed ticks wrap with the time counter
  assign elapsed_d = time_i - stamp_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elapsed_q <= elapsed_d;
      heard_q   <= heard_i;
    end
  end

  assign elapsed_x = CMP_W'(elapsed_q);

  // Never-heard nodes count as dead
  always_comb begin
    if (!heard_q) begin
      live_o = LV_DEAD;
    end else if (elapsed_x >= CMP_W'(dead_i)) begin
      live_o = LV_DEAD;
    end else if (elapsed_x >= CMP_W'(suspect_i)) begin
      live_o = LV_SUSPECT;
    end else begin
      live_o = LV_ALIVE;
    end
  end

  assign heard_o = heard_q;

endmodule

/* src/heartbeat_failure_detector.sv */
// Heartbeat failure detector top level: node tables in RAM, walker and control.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   in       | in_valid_i / in_stall_o | func_i, node_i
//   out      | out_valid_o/ out_stall_i| node_state_o, alive_count_o, quorum_healthy_o
//   cfg      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Tick, heartbeat and unused codes go through one read of the node state RAM and a
// response state. Reclassify reads each node entry in use through a three-stage
// read/classify/write-back walk, then reads the node state RAM and responds.
// Reset clears time, counts and per-entry valid bits at once; no clearing pass.
// A stalled output holds its beat; the block takes its next item up to the response state and waits.
module heartbeat_failure_detector import hbfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [NODE_W-1:0]     node_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            node_state_o,
  output logic [CNT_W-1:0]      alive_count_o,
  output logic                  quorum_healthy_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  hbfd_state_e state_q, state_d;

  logic [THR_W-1:0]      suspect_q, dead_q;
  logic [CNT_W-1:0]      quorum_q, num_nodes_q, active;
  logic [TIME_WIDTH-1:0] time_q;
  func_t                 func_q;
  logic [NODE_W-1:0]     node_q;
  logic [MAX_NODES-1:0]  valid_q;
  logic                  rv_q;
  logic [CNT_W-1:0]      cnt_q, acc_q, alive_q;
  logic                  p1_q, p2_q;
  logic [IDX_W-1:0]      idx1_q, idx2_q;
  logic                  out_valid_q, quorum_ok_q;
  live_t                 out_state_q;
  logic [CNT_W-1:0]      out_alive_q;

  logic                  in_fire, resp_fire, issue, walk_done, present;
  logic                  rd_en, st_we, lh_we;
  logic [IDX_W-1:0]      raddr, st_waddr, node_idx;
  node_ent_t             st_wdata, st_rdata, cur;
  logic [TIME_WIDTH-1:0] lh_rdata;
  logic                  cls_heard;
  live_t                 cls_live;

  assign active    = active_nodes(num_nodes_q);
  assign node_idx  = idx_of(CNT_W'(node_q));
  assign present   = CNT_W'(node_q) < active;
  assign in_fire   = in_valid_i && !in_stall_o;
  assign resp_fire = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);
  assign issue     = (state_q == S_WALK) && (cnt_q < active);
  assign walk_done = (state_q == S_WALK) && !issue && !p1_q && !p2_q;

  // Entry that was never written reads as not heard, dead
  assign cur = rv_q ? st_rdata : node_ent_t'{heard: 1'b0, live: LV_DEAD};

  // Next state and memory controls
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    raddr      = node_idx;
    st_we      = 1'b0;
    lh_we      = 1'b0;
    st_waddr   = node_idx;
    st_wdata   = '{heard: 1'b1, live: cur.live};
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (func_i == FUNC_RECLASS) ? S_WALK : S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (resp_fire) begin
          state_d = S_IDLE;
          if (func_q == FUNC_BEAT && present) begin
            st_we = 1'b1;
            lh_we = 1'b1;
          end
        end
      end
      S_WALK: begin
        rd_en    = issue;
        raddr    = idx_of(cnt_q);
        st_we    = p2_q;
        st_waddr = idx2_q;
        st_wdata = '{heard: cls_heard, live: cls_live};
        if (walk_done) begin
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suspect_q   <= THR_W'(3);
      dead_q      <= THR_W'(10);
      quorum_q    <= CNT_W'(1);
      num_nodes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUSPECT: suspect_q   <= cfg_wdata_i[THR_W-1:0];
        CFG_DEAD:    dead_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_QUORUM:  quorum_q    <= cfg_wdata_i[CNT_W-1:0];
        CFG_NODES:   num_nodes_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      node_q <= node_i;
    end
  end

  // Time, valid bits, walk pipeline and alive count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      valid_q <= '0;
      rv_q    <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
      alive_q <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
    end else begin
      if (resp_fire && func_q == FUNC_TICK) begin
        time_q <= time_q + TIME_WIDTH'(1);
      end
      if (st_we) begin
        valid_q[st_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rv_q <= valid_q[raddr];
      end
      if (in_fire) begin
        cnt_q <= '0;
        acc_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (p2_q && cls_live == LV_ALIVE && acc_q != '1) begin
        acc_q <= acc_q + CNT_W'(1);
      end
      if (walk_done) begin
        alive_q <= acc_q;
      end
      p1_q <= issue;
      p2_q <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= raddr;
    idx2_q <= idx1_q;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_state_q <= present ? cur.live : LV_ABSENT;
      out_alive_q <= alive_q;
      quorum_ok_q <= ({1'b0, alive_q} + 7'd1) >= {1'b0, quorum_q};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign node_state_o     = out_state_q;
  assign alive_count_o    = out_alive_q;
  assign quorum_healthy_o = quorum_ok_q;

  // Node state table: heard flag and liveness
  hbfd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  // Last heartbeat time table
  hbfd_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_NODES)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (node_idx),
    .wdata_i (time_q),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (lh_rdata)
  );

  hbfd_classify u_classify (
    .clk_i     (clk_i),
    .en_i      (p1_q),
    .time_i    (time_q),
    .stamp_i   (lh_rdata),
    .heard_i   (rv_q && st_rdata.heard),
    .suspect_i (suspect_q),
    .dead_i    (dead_q),
    .heard_o   (cls_heard),
    .live_o    (cls_live)
  );

endmodule

/* src/hbfd_checker.sv */
// Port-level checks for the heartbeat failure detector, bound to the top level.
module hbfd_checker import hbfd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           node_state_o,
  input logic [CNT_W-1:0]     alive_count_o,
  input logic                 quorum_healthy_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(node_state_o)
      && $stable(alive_count_o) && $stable(quorum_healthy_o))
    else $error("stalled result beat changed");

  // Alive count never exceeds the node table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(alive_count_o) <= MAX_NODES)
    else $error("alive count above table size");

  // An accepted beat keeps the input stalled for its read and response cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o)
    else $error("input accepted during an item in progress");

endmodule

bind heartbeat_failure_detector hbfd_checker u_hbfd_checker (.*);
